// File: src/lrbc_pkg.sv
package lrbc_pkg;

    // Time base width of the internal timestamps (valid 16 to 64).
    localparam int TIME_BITS = 32;
    localparam int REG_W     = 32;
    localparam int NOW_W     = 32;
    localparam int JIT_W     = 9;
    localparam int EV_W      = 2;
    localparam int CFG_IDX_W = 2;

    // Compare width that holds both a time and a register value.
    localparam int CMP_W = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;
    // Retry sum: time + backoff + jitter, two carry bits of headroom.
    localparam int SUM_W = CMP_W + 2;
    // Doubled backoff, one bit wider so it cannot wrap.
    localparam int DBL_W = REG_W + 1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [REG_W-1:0]     t_reg;
    typedef logic [JIT_W-1:0]     t_jitter;
    typedef logic [CMP_W-1:0]     t_cmp;
    typedef logic [SUM_W-1:0]     t_sum;
    typedef logic [DBL_W-1:0]     t_dbl;
    typedef logic [NOW_W-1:0]     t_now;

    localparam t_reg TIMEOUT_RST = 32'd15000;
    localparam t_reg BO_INIT_RST = 32'd1000;
    localparam t_reg BO_MAX_RST  = 32'd60000;

    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 2'd0,
        EV_LINK_UP   = 2'd1,
        EV_LINK_LOST = 2'd2,
        EV_TIMEOUT   = 2'd3
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_BO_INIT = 2'd1,
        CFG_BO_MAX  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_reg timeout;
        t_reg bo_init;
        t_reg bo_max;
    } t_cfg;

    typedef struct packed {
        logic    cmd;
        t_time   now;
        logic    link_up;
        t_jitter jitter;
    } t_item;

    typedef struct packed {
        logic   launch;
        logic   abort;
        t_event ev;
        logic   busy;
        t_time  retry_due;
        t_reg   backoff;
    } t_result;

endpackage

// File: src/lrbc_in_if.sv
interface lrbc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [lrbc_pkg::NOW_W-1:0]    now_ms;
    logic                          link_up;
    logic [lrbc_pkg::JIT_W-1:0]    jitter_ms;

    modport source (output valid, cmd, now_ms, link_up, jitter_ms, input ready);
    modport sink   (input valid, cmd, now_ms, link_up, jitter_ms, output ready);
endinterface

// File: src/lrbc_out_if.sv
interface lrbc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          launch_attempt;
    logic                          abort_attempt;
    logic [lrbc_pkg::EV_W-1:0]     event_code;
    logic                          attempt_busy;
    logic [lrbc_pkg::NOW_W-1:0]    retry_due_ms;
    logic [lrbc_pkg::REG_W-1:0]    current_backoff_ms;

    modport source (output valid, launch_attempt, abort_attempt, event_code,
                    attempt_busy, retry_due_ms, current_backoff_ms, input ready);
    modport sink   (input valid, launch_attempt, abort_attempt, event_code,
                    attempt_busy, retry_due_ms, current_backoff_ms, output ready);
endinterface

// File: src/lrbc_cfg_regs.sv
module lrbc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lrbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lrbc_pkg::REG_W-1:0]     i_cfg_wdata,
    output lrbc_pkg::t_cfg                 o_cfg
);

    lrbc_pkg::t_cfg r_cfg;
    lrbc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (lrbc_pkg::t_cfg_idx'(i_cfg_idx))
                lrbc_pkg::CFG_TIMEOUT: n_cfg.timeout = i_cfg_wdata;
                lrbc_pkg::CFG_BO_INIT: n_cfg.bo_init = i_cfg_wdata;
                lrbc_pkg::CFG_BO_MAX:  n_cfg.bo_max  = i_cfg_wdata;
                default:               n_cfg = r_cfg;  // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout <= lrbc_pkg::TIMEOUT_RST;
            r_cfg.bo_init <= lrbc_pkg::BO_INIT_RST;
            r_cfg.bo_max  <= lrbc_pkg::BO_MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/lrbc_step.sv
module lrbc_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  lrbc_pkg::t_item   i_item,
    input  lrbc_pkg::t_cfg    i_cfg,
    output lrbc_pkg::t_result o_res
);

    logic                  r_was_up;
    logic                  r_active;
    lrbc_pkg::t_time       r_start;
    lrbc_pkg::t_time       r_retry;
    lrbc_pkg::t_reg        r_backoff;

    logic                  n_was_up;
    logic                  n_active;
    lrbc_pkg::t_time       n_start;
    lrbc_pkg::t_time       n_retry;
    lrbc_pkg::t_reg        n_backoff;

    lrbc_pkg::t_reg        bo_base;
    lrbc_pkg::t_sum        plan_sum;
    lrbc_pkg::t_time       plan_retry;
    lrbc_pkg::t_dbl        bo_dbl;
    lrbc_pkg::t_reg        plan_backoff;
    lrbc_pkg::t_time       age;
    logic                  poll;
    logic                  rise;
    logic                  fall;
    logic                  timeout;
    logic                  plan;
    logic                  idle_launch;
    logic                  launch;
    lrbc_pkg::t_event      ev;

    always_comb begin
        // zero backoff falls back to the initial delay
        bo_base      = (r_backoff == '0) ? i_cfg.bo_init : r_backoff;
        plan_sum     = lrbc_pkg::t_sum'(i_item.now) + lrbc_pkg::t_sum'(bo_base)
                     + lrbc_pkg::t_sum'(i_item.jitter);
        plan_retry   = lrbc_pkg::t_time'(plan_sum);
        bo_dbl       = lrbc_pkg::t_dbl'(bo_base) << 1;
        plan_backoff = (bo_dbl < lrbc_pkg::t_dbl'(i_cfg.bo_max))
                     ? lrbc_pkg::t_reg'(bo_dbl) : i_cfg.bo_max;
        age          = i_item.now - r_start;

        poll    = !i_item.cmd;
        rise    = poll && i_item.link_up && !r_was_up;
        fall    = poll && !i_item.link_up && r_was_up;
        timeout = poll && !i_item.link_up && !r_was_up && r_active
               && (lrbc_pkg::t_cmp'(age) >= lrbc_pkg::t_cmp'(i_cfg.timeout));
        plan    = fall || timeout;

        if (i_item.cmd || rise) begin
            n_retry   = i_item.now;
            n_backoff = i_cfg.bo_init;
        end else if (plan) begin
            n_retry   = plan_retry;
            n_backoff = plan_backoff;
        end else begin
            n_retry   = r_retry;
            n_backoff = r_backoff;
        end

        // plain unsigned due test against the updated retry time
        idle_launch = poll && !i_item.link_up && (fall || !r_active || timeout)
                   && (i_item.now >= n_retry);
        launch      = i_item.cmd || idle_launch;

        if (launch) begin
            n_active = 1'b1;
        end else if (rise || fall || timeout) begin
            n_active = 1'b0;
        end else begin
            n_active = r_active;
        end
        n_start  = launch ? i_item.now : r_start;
        n_was_up = i_item.cmd ? r_was_up : i_item.link_up;

        if (rise) begin
            ev = lrbc_pkg::EV_LINK_UP;
        end else if (fall) begin
            ev = lrbc_pkg::EV_LINK_LOST;
        end else if (timeout) begin
            ev = lrbc_pkg::EV_TIMEOUT;
        end else begin
            ev = lrbc_pkg::EV_NONE;
        end

        o_res.launch    = launch;
        o_res.abort     = timeout;
        o_res.ev        = ev;
        o_res.busy      = n_active;
        o_res.retry_due = n_retry;
        o_res.backoff   = n_backoff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_up  <= 1'b0;
            r_active  <= 1'b0;
            r_start   <= '0;
            r_retry   <= '0;
            r_backoff <= '0;
        end else if (i_en) begin
            r_was_up  <= n_was_up;
            r_active  <= n_active;
            r_start   <= n_start;
            r_retry   <= n_retry;
            r_backoff <= n_backoff;
        end
    end

endmodule

// File: src/link_retry_backoff_controller_unit.sv
// Channel   Dir  Port     Word contents
// --------  ---  -------  ----------------------------------------------------
// input     in   i_in     cmd, now_ms, link_up, jitter_ms
// result    out  o_out    launch_attempt, abort_attempt, event_code,
//                         attempt_busy, retry_due_ms, current_backoff_ms
// config    in   i_cfg_*  write enable, register index, 32-bit write data
//
// One word per cycle sustained while the result register is not stalled; an accepted
// word passes the input register, then the step logic into the result register.
// Backoff state updates when a word moves from the input to the result register.
// Synchronous active-low reset clears state; registers return to 15000/1000/60000.
// A stalled result register holds; the input register keeps taking words as
// long as the result register drains in the same cycle.
module link_retry_backoff_controller_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lrbc_in_if.sink                        i_in,
    lrbc_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [lrbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lrbc_pkg::REG_W-1:0]     i_cfg_wdata
);

    lrbc_pkg::t_cfg    cfg;
    lrbc_pkg::t_result step_res;

    // input register
    logic              r_s1_v;
    lrbc_pkg::t_item   r_s1;
    // result register
    logic              r_s2_v;
    lrbc_pkg::t_result r_s2;

    logic              s2_load;
    logic              s1_load;

    lrbc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // step logic and backoff state; state advances with each word moved on
    lrbc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s2_load),
        .i_item  (r_s1),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    assign s2_load    = r_s1_v && (!r_s2_v || o_out.ready);
    assign i_in.ready = !r_s1_v || s2_load;
    assign s1_load    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_load) begin
            r_s1_v <= 1'b1;
        end else if (s2_load) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1.cmd     <= i_in.cmd;
            r_s1.now     <= lrbc_pkg::t_time'(i_in.now_ms);
            r_s1.link_up <= i_in.link_up;
            r_s1.jitter  <= i_in.jitter_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_load) begin
            r_s2_v <= 1'b1;
        end else if (o_out.ready) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2 <= step_res;
        end
    end

    assign o_out.valid              = r_s2_v;
    assign o_out.launch_attempt     = r_s2.launch;
    assign o_out.abort_attempt      = r_s2.abort;
    assign o_out.event_code         = r_s2.ev;
    assign o_out.attempt_busy       = r_s2.busy;
    assign o_out.retry_due_ms       = lrbc_pkg::t_now'(r_s2.retry_due);
    assign o_out.current_backoff_ms = r_s2.backoff;

`ifndef SYNTHESIS
    a_abort_is_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.abort_attempt) |-> (o_out.event_code == lrbc_pkg::EV_TIMEOUT))
        else $error("abort without timeout event");

    a_launch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.launch_attempt) |-> o_out.attempt_busy)
        else $error("launch left attempt idle");

    a_link_up_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.event_code == lrbc_pkg::EV_LINK_UP))
            |-> (!o_out.attempt_busy && !o_out.launch_attempt && !o_out.abort_attempt))
        else $error("link up step left an attempt running");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_v && r_s2_v && !o_out.ready))
        else $error("input stalled without a full pipe");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_load |=> r_s2_v)
        else $error("result register lost a word");
`endif

endmodule
